// File: rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at each rising edge outside reset.
`define ASRA_ASSERT(lbl, clk_i, rst_ni, prop, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
        else $error(msg);

// Condition must never be seen at a rising edge outside reset.
`define ASRA_ASSERT_NEVER(lbl, clk_i, rst_ni, cond, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
        else $error(msg);

`endif

// File: rtl/asra_pkg.sv
// Shared types and constants of the span row accumulator.
`default_nettype none

package asra_pkg;

    // field widths
    localparam int FRAC_BITS  = 8;
    localparam int EDGE_W     = 19;
    localparam int WIDTH_W    = 11;
    localparam int INDEX_W    = 10;
    localparam int TOTAL_W    = 19;
    localparam int VALUE_W    = 16;
    // pixel counter wide enough for the largest row (4096 pixels)
    localparam int SPAN_IDX_W = 13;
    localparam int POS_W      = SPAN_IDX_W + FRAC_BITS;
    // per-pixel coverage amount, 0..256
    localparam int AMT_W      = FRAC_BITS + 1;

    localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET = 11'd1024;
    localparam logic [AMT_W:0]     ONE_PIXEL_AMT   = 10'd256;

    // request command codes
    localparam logic CMD_PAINT = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef logic [SPAN_IDX_W-1:0] idx_t;
    typedef logic [VALUE_W-1:0]    value_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DONE,
        ST_RD_DONE
    } state_t;

    // clamped span, ready for the pixel walk
    typedef struct packed {
        logic                 bad;
        logic                 empty;
        logic [SPAN_IDX_W-1:0] first;
        logic [SPAN_IDX_W-1:0] last;
        logic [FRAC_BITS-1:0]  lo_cut;
        logic [FRAC_BITS-1:0]  hi_cut;
        logic [TOTAL_W-1:0]    total;
    } span_t;

endpackage

`default_nettype wire

// File: rtl/asra_channels.sv
// Channel interfaces: request, result and configuration write.
`default_nettype none

interface asra_item_if;
    logic                              valid;
    logic                              ready;
    logic                              cmd;
    logic signed [asra_pkg::EDGE_W-1:0] left_edge;
    logic signed [asra_pkg::EDGE_W-1:0] right_edge;
    logic [asra_pkg::INDEX_W-1:0]       read_index;

    modport source (output valid, cmd, left_edge, right_edge, read_index, input ready);
    modport sink   (input valid, cmd, left_edge, right_edge, read_index, output ready);
endinterface

interface asra_result_if;
    logic                         valid;
    logic                         ready;
    logic [asra_pkg::TOTAL_W-1:0] added_total;
    logic [asra_pkg::VALUE_W-1:0] pixel_value;
    logic                         bad_segment;

    modport source (output valid, added_total, pixel_value, bad_segment, input ready);
    modport sink   (input valid, added_total, pixel_value, bad_segment, output ready);
endinterface

interface asra_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [asra_pkg::WIDTH_W-1:0] row_width;

    modport source (output valid, row_width, input ready);
    modport sink   (input valid, row_width, output ready);
endinterface

`default_nettype wire

// File: rtl/asra_span_prep.sv
// Span clamp: turns raw edges into first/last pixel, edge cuts and total.
`default_nettype none

module asra_span_prep #(
    parameter int ROW_PIXELS = 1024
) (
    input  wire logic [asra_pkg::WIDTH_W-1:0]        row_width,
    input  wire logic signed [asra_pkg::EDGE_W-1:0]  left_edge,
    input  wire logic signed [asra_pkg::EDGE_W-1:0]  right_edge,
    output asra_pkg::span_t                          span
);

    localparam asra_pkg::idx_t ROW_LIMIT = asra_pkg::idx_t'(ROW_PIXELS);
    localparam logic signed [asra_pkg::POS_W:0] ROUND_UP =
        {{(asra_pkg::POS_W + 1 - asra_pkg::FRAC_BITS){1'b0}}, {asra_pkg::FRAC_BITS{1'b1}}};
    localparam logic signed [asra_pkg::POS_W:0] ZERO_POS = '0;

    asra_pkg::idx_t                    width_eff;
    asra_pkg::idx_t                    first_pix;
    asra_pkg::idx_t                    end_pix;
    logic signed [asra_pkg::POS_W:0]   lim;
    logic signed [asra_pkg::POS_W:0]   x0;
    logic signed [asra_pkg::POS_W:0]   x1;
    logic signed [asra_pkg::POS_W:0]   c0;
    logic signed [asra_pkg::POS_W:0]   c1;
    logic signed [asra_pkg::POS_W:0]   c1_up;
    logic signed [asra_pkg::POS_W:0]   diff;
    logic                              reversed;
    logic                              outside;
    logic                              no_pixels;

    // effective row limit in 1/256 pixel
    always_comb
    begin
        width_eff = (asra_pkg::idx_t'(row_width) > ROW_LIMIT) ? ROW_LIMIT
                                                              : asra_pkg::idx_t'(row_width);
        lim = {1'b0, width_eff, {asra_pkg::FRAC_BITS{1'b0}}};
    end

    // sign-extend, classify and clamp the edges
    always_comb
    begin
        x0 = {{(asra_pkg::POS_W + 1 - asra_pkg::EDGE_W){left_edge[asra_pkg::EDGE_W-1]}},
              left_edge};
        x1 = {{(asra_pkg::POS_W + 1 - asra_pkg::EDGE_W){right_edge[asra_pkg::EDGE_W-1]}},
              right_edge};
        reversed = x1 < x0;
        outside  = (x1 < ZERO_POS) || (x0 > lim);
        c0 = (x0 < ZERO_POS) ? ZERO_POS : ((x0 > lim) ? lim : x0);
        c1 = (x1 < ZERO_POS) ? ZERO_POS : ((x1 > lim) ? lim : x1);
        c1_up = c1 + ROUND_UP;
        diff  = c1 - c0;
    end

    // pixel range and edge cuts
    always_comb
    begin
        first_pix = c0[asra_pkg::POS_W-1:asra_pkg::FRAC_BITS];
        end_pix   = c1_up[asra_pkg::POS_W-1:asra_pkg::FRAC_BITS];
        no_pixels = reversed || outside || (end_pix <= first_pix);

        span.bad    = reversed;
        span.empty  = no_pixels;
        span.first  = first_pix;
        span.last   = end_pix - asra_pkg::idx_t'(1);
        span.lo_cut = c0[asra_pkg::FRAC_BITS-1:0];
        span.hi_cut = (~c1[asra_pkg::FRAC_BITS-1:0]) + {{(asra_pkg::FRAC_BITS-1){1'b0}}, 1'b1};
        span.total  = no_pixels ? '0 : diff[asra_pkg::TOTAL_W-1:0];
    end

endmodule

`default_nettype wire

// File: rtl/antialiased_span_row_accumulator_core.sv
// Top level: row coverage store with span paint and read-and-clear requests.
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+------------------------------------------------
//  cfg     | in  | valid/ready | row_width
//  item    | in  | valid/ready | cmd, left_edge, right_edge, read_index
//  result  | out | valid/ready | added_total, pixel_value, bad_segment
//
// A paint walks the pixels that the clamped span touches, one pixel read per cycle
// (read-modify-write through the single row memory); a reversed or empty span
// touches no pixel. A read-and-clear reads an in-range entry and writes it to zero.
// After reset a clearing pass writes zero to all ROW_PIXELS entries, one per
// cycle; item.ready stays low meanwhile. One request is in work at a time; the
// next is taken while the previous result still waits in the output register.
`default_nettype none

module antialiased_span_row_accumulator_core #(
    parameter int ROW_PIXELS = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    asra_cfg_if.sink      cfg,
    asra_item_if.sink     item,
    asra_result_if.source result
);

    localparam int AW = $clog2(ROW_PIXELS);
    localparam logic [AW-1:0]  LAST_ADDR = AW'(ROW_PIXELS - 1);
    localparam asra_pkg::idx_t ROW_LIMIT = asra_pkg::idx_t'(ROW_PIXELS);

    // row memory and its registered read data
    logic [PIXEL_BITS-1:0] row_mem [ROW_PIXELS];
    logic [PIXEL_BITS-1:0] rd_data_reg;

    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [PIXEL_BITS-1:0] mem_wdata;

    asra_pkg::state_t state_reg, state_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [asra_pkg::WIDTH_W-1:0] row_width_reg, row_width_next;

    asra_pkg::span_t  span_new;
    asra_pkg::span_t  span_reg, span_next;
    asra_pkg::idx_t   cur_reg, cur_next;
    logic             rd_hit_reg, rd_hit_next;
    logic [AW-1:0]    rd_addr_reg, rd_addr_next;

    logic                         wr_valid_reg, wr_valid_next;
    logic [AW-1:0]                wr_addr_reg, wr_addr_next;
    logic [asra_pkg::AMT_W-1:0]   wr_amt_reg, wr_amt_next;

    logic                         out_valid_reg, out_valid_next;
    logic [asra_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic [asra_pkg::VALUE_W-1:0] value_reg, value_next;
    logic                         bad_reg, bad_next;

    logic                   item_take;
    logic                   out_free;
    logic                   out_load;
    logic                   idx_hit;
    asra_pkg::idx_t         idx_ext;
    logic                   at_first;
    logic                   at_last;
    logic [asra_pkg::AMT_W:0] amt_full;
    logic [PIXEL_BITS:0]    acc_sum;
    logic [PIXEL_BITS-1:0]  acc_sat;

    // span clamp on the incoming request
    asra_span_prep #(
        .ROW_PIXELS (ROW_PIXELS)
    ) u_span_prep (
        .row_width  (row_width_reg),
        .left_edge  (item.left_edge),
        .right_edge (item.right_edge),
        .span       (span_new)
    );

    // handshakes
    assign cfg.ready  = 1'b1;
    assign item.ready = (state_reg == asra_pkg::ST_IDLE);
    assign item_take  = item.valid && item.ready;
    assign out_free   = !out_valid_reg || result.ready;
    assign out_load   = out_free &&
                        ((state_reg == asra_pkg::ST_DONE) || (state_reg == asra_pkg::ST_RD_DONE));

    assign result.valid       = out_valid_reg;
    assign result.added_total = total_reg;
    assign result.pixel_value = value_reg;
    assign result.bad_segment = bad_reg;

    // read index check
    assign idx_ext = asra_pkg::idx_t'(item.read_index);
    assign idx_hit = idx_ext < ROW_LIMIT;

    // coverage for the current pixel of the walk
    always_comb
    begin
        at_first = (cur_reg == span_reg.first);
        at_last  = (cur_reg == span_reg.last);
        amt_full = asra_pkg::ONE_PIXEL_AMT
                 - (at_first ? {2'b00, span_reg.lo_cut} : '0)
                 - (at_last  ? {2'b00, span_reg.hi_cut} : '0);
    end

    // saturating add of the write-back stage
    always_comb
    begin
        acc_sum = {1'b0, rd_data_reg}
                + {{(PIXEL_BITS + 1 - asra_pkg::AMT_W){1'b0}}, wr_amt_reg};
        acc_sat = acc_sum[PIXEL_BITS] ? '1 : acc_sum[PIXEL_BITS-1:0];
    end

    // memory port control
    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = '0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        if (item_take && (item.cmd == asra_pkg::CMD_READ) && idx_hit)
        begin
            mem_re    = 1'b1;
            mem_raddr = idx_ext[AW-1:0];
        end
        else if ((state_reg == asra_pkg::ST_WALK) && !span_reg.empty)
        begin
            mem_re    = 1'b1;
            mem_raddr = cur_reg[AW-1:0];
        end
        if (state_reg == asra_pkg::ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
        end
        else if (wr_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = wr_addr_reg;
            mem_wdata = acc_sat;
        end
        else if ((state_reg == asra_pkg::ST_RD_DONE) && out_free && rd_hit_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = rd_addr_reg;
        end
    end

    // row memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= row_mem[mem_raddr];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            asra_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = asra_pkg::ST_IDLE;
                end
            end
            asra_pkg::ST_IDLE:
            begin
                if (item_take)
                begin
                    state_next = (item.cmd == asra_pkg::CMD_PAINT) ? asra_pkg::ST_WALK
                                                                   : asra_pkg::ST_RD_DONE;
                end
            end
            asra_pkg::ST_WALK:
            begin
                if (span_reg.empty || at_last)
                begin
                    state_next = asra_pkg::ST_DONE;
                end
            end
            asra_pkg::ST_DONE,
            asra_pkg::ST_RD_DONE:
            begin
                if (out_free)
                begin
                    state_next = asra_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = asra_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        clr_cnt_next   = (state_reg == asra_pkg::ST_CLEAR) ? clr_cnt_reg + AW'(1) : clr_cnt_reg;
        row_width_next = (cfg.valid && cfg.ready) ? cfg.row_width : row_width_reg;

        span_next    = span_reg;
        cur_next     = cur_reg;
        rd_hit_next  = rd_hit_reg;
        rd_addr_next = rd_addr_reg;
        if (item_take)
        begin
            span_next    = span_new;
            cur_next     = span_new.first;
            rd_hit_next  = idx_hit;
            rd_addr_next = idx_ext[AW-1:0];
        end
        else if (state_reg == asra_pkg::ST_WALK)
        begin
            cur_next = cur_reg + asra_pkg::idx_t'(1);
        end

        wr_valid_next = (state_reg == asra_pkg::ST_WALK) && !span_reg.empty;
        wr_addr_next  = cur_reg[AW-1:0];
        wr_amt_next   = amt_full[asra_pkg::AMT_W-1:0];
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        total_next     = total_reg;
        value_next     = value_reg;
        bad_next       = bad_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            if (state_reg == asra_pkg::ST_DONE)
            begin
                total_next = span_reg.total;
                value_next = '0;
                bad_next   = span_reg.bad;
            end
            else
            begin
                total_next = '0;
                value_next = rd_hit_reg ? asra_pkg::value_t'(rd_data_reg) : '0;
                bad_next   = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= asra_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            row_width_reg <= asra_pkg::ROW_WIDTH_RESET;
            wr_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            row_width_reg <= row_width_next;
            wr_valid_reg  <= wr_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        span_reg    <= span_next;
        cur_reg     <= cur_next;
        rd_hit_reg  <= rd_hit_next;
        rd_addr_reg <= rd_addr_next;
        wr_addr_reg <= wr_addr_next;
        wr_amt_reg  <= wr_amt_next;
        total_reg   <= total_next;
        value_reg   <= value_next;
        bad_reg     <= bad_next;
    end

endmodule

`default_nettype wire

// File: rtl/asra_checker.sv
// Port-level checker for the span row accumulator, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module asra_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         item_valid,
    input wire logic                         item_ready,
    input wire logic                         result_valid,
    input wire logic                         result_ready,
    input wire logic [asra_pkg::TOTAL_W-1:0] added_total,
    input wire logic [asra_pkg::VALUE_W-1:0] pixel_value,
    input wire logic                         bad_segment
);

    logic [1:0] pending_reg, pending_next;
    logic       item_take;
    logic       result_take;

    // requests taken whose result has not been taken yet
    assign item_take   = item_valid && item_ready;
    assign result_take = result_valid && result_ready;

    always_comb
    begin
        pending_next = pending_reg + {1'b0, item_take} - {1'b0, result_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `ASRA_ASSERT(a_result_hold, clk, rst_n, result_valid && !result_ready |=> result_valid && $stable(added_total) && $stable(pixel_value) && $stable(bad_segment), "result changed while stalled")
    `ASRA_ASSERT_NEVER(a_no_orphan, clk, rst_n, result_valid && (pending_reg == 2'd0), "result without a request")
    `ASRA_ASSERT(a_one_in_work, clk, rst_n, pending_reg == 2'd2 |-> !item_ready, "third request taken")
    `ASRA_ASSERT(a_field_excl, clk, rst_n, result_valid && (bad_segment || pixel_value != '0) |-> added_total == '0 && (!bad_segment || pixel_value == '0), "result fields overlap")

endmodule

bind antialiased_span_row_accumulator_core asra_checker u_asra_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .added_total  (result.added_total),
    .pixel_value  (result.pixel_value),
    .bad_segment  (result.bad_segment)
);

`default_nettype wire
